>>> src/hckr_pkg.sv
package hckr_pkg;

  // Register stages: three front stages, then one per hue quotient bit.
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned HUE_BITS     = 13;
  localparam int unsigned SAT_BITS     = 8;
  localparam int unsigned NSTG         = FRONT_STAGES + HUE_BITS;

  // Configuration register indexes.
  localparam logic [1:0] REG_HUE_LOW   = 2'd0;
  localparam logic [1:0] REG_HUE_HIGH  = 2'd1;
  localparam logic [1:0] REG_VALUE_MIN = 2'd2;

  localparam logic [8:0] HUE_LOW_RST   = 9'd88;
  localparam logic [8:0] HUE_HIGH_RST  = 9'd175;
  localparam logic [7:0] VALUE_MIN_RST = 8'd120;

  // Which channel holds the maximum.
  localparam logic [1:0] SEC_GREY  = 2'd0;
  localparam logic [1:0] SEC_RED   = 2'd1;
  localparam logic [1:0] SEC_GREEN = 2'd2;
  localparam logic [1:0] SEC_BLUE  = 2'd3;

  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_ctl_t;

  typedef struct packed {
    logic [23:0]       fg;
    logic [23:0]       bg;
    logic [7:0]        mx;
    logic [7:0]        mn;
    logic [1:0]        sec;
    logic signed [8:0] diff;
  } st_a_t;

  typedef struct packed {
    logic [23:0] fg;
    logic [23:0] bg;
    logic [7:0]  mx;
    logic [7:0]  d;
    logic        grey;
    logic [10:0] m;
  } st_b_t;

  typedef struct packed {
    logic [23:0] fg;
    logic [23:0] bg;
    logic [7:0]  mx;
    logic [7:0]  d;
    logic        grey;
    logic [16:0] n;
    logic [16:0] lo_p;
    logic [16:0] hi_p;
    logic [15:0] sd;
  } st_c_t;

  typedef struct packed {
    logic [23:0]         fg;
    logic [23:0]         bg;
    logic [7:0]          mx;
    logic [7:0]          d;
    logic                grey;
    logic                key;
    logic [7:0]          hrem;
    logic [HUE_BITS-1:0] hq;
    logic [7:0]          srem;
    logic [SAT_BITS-1:0] sq;
  } st_div_t;

  // One restoring division step: returns the quotient bit above the new remainder.
  // The remainder stays below the divisor, so it fits in eight bits.
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic b,
                                          input logic [7:0] dv);
    logic [8:0] t;
    logic [8:0] s;
    t = {rem, b};
    s = t - {1'b0, dv};
    if (t >= {1'b0, dv}) begin
      div_step = {1'b1, s[7:0]};
    end else begin
      div_step = {1'b0, t[7:0]};
    end
  endfunction

endpackage

>>> src/hsv_chroma_key_replace.sv
// HSV chroma key with background replacement.
// Input stream (in_*): each word carries a foreground pixel and the background
// pixel at the same position. Output stream (out_*): each word carries the
// composited pixel, the foreground hue in sixteenths of a degree, saturation
// and value; out_tuser is high when the pixel was keyed and replaced.
// Configuration (cfg_*): hue low bound, hue high bound and value threshold,
// written by index; cfg_ready is always high. Write only while no word is in
// flight. Indexes beyond the list are ignored.
// Throughput is one word per clock while out_tready stays high. There are
// sixteen register stages and the first loads at the accepting edge: three
// stages find max/min, the hue numerator and the key-range products, then
// thirteen stages each produce one hue quotient bit by restoring division
// (saturation shares the first eight of them).
// Reset clears every stage's valid bit and loads the default key range.
// When the receiver holds out_tready low, the last stage holds its word and
// earlier stages keep filling until every stage is occupied; in_tready then
// drops. No word is lost or repeated.
module hsv_chroma_key_replace (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue from bit 0 up
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_red, out_green, out_blue, hue_sixteenths, saturation, brightness,
  // three zero bits, from bit 0 up
  output logic [55:0] out_tdata,
  // keyed
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int unsigned FS = hckr_pkg::FRONT_STAGES;
  localparam int unsigned HB = hckr_pkg::HUE_BITS;

  hckr_pkg::pipe_ctl_t ctl;

  logic [8:0] hue_low_r;
  logic [8:0] hue_high_r;
  logic [7:0] value_min_r;

  hckr_pkg::st_a_t   a_r, a_nxt;
  hckr_pkg::st_b_t   b_r, b_nxt;
  hckr_pkg::st_c_t   c_r, c_nxt;
  hckr_pkg::st_div_t dv_r [HB];

  logic [7:0] fr, fgn, fb;

  hckr_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .in_ready  (in_tready),
    .ctl       (ctl)
  );

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r   <= hckr_pkg::HUE_LOW_RST;
      hue_high_r  <= hckr_pkg::HUE_HIGH_RST;
      value_min_r <= hckr_pkg::VALUE_MIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hckr_pkg::REG_HUE_LOW:   hue_low_r   <= cfg_data;
        hckr_pkg::REG_HUE_HIGH:  hue_high_r  <= cfg_data;
        hckr_pkg::REG_VALUE_MIN: value_min_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Stage A: maximum, minimum, dominant channel and the hue difference term.
  assign fr  = in_tdata[7:0];
  assign fgn = in_tdata[15:8];
  assign fb  = in_tdata[23:16];

  always_comb begin
    a_nxt.fg = in_tdata[23:0];
    a_nxt.bg = in_tdata[47:24];
    priority if (fr == fgn && fr == fb) begin
      a_nxt.sec  = hckr_pkg::SEC_GREY;
      a_nxt.mx   = fr;
      a_nxt.mn   = fr;
      a_nxt.diff = '0;
    end else if (fr >= fgn && fr >= fb) begin
      a_nxt.sec  = hckr_pkg::SEC_RED;
      a_nxt.mx   = fr;
      a_nxt.mn   = (fgn < fb) ? fgn : fb;
      a_nxt.diff = $signed({1'b0, fgn}) - $signed({1'b0, fb});
    end else if (fgn >= fr && fgn >= fb) begin
      a_nxt.sec  = hckr_pkg::SEC_GREEN;
      a_nxt.mx   = fgn;
      a_nxt.mn   = (fr < fb) ? fr : fb;
      a_nxt.diff = $signed({1'b0, fb}) - $signed({1'b0, fr});
    end else begin
      a_nxt.sec  = hckr_pkg::SEC_BLUE;
      a_nxt.mx   = fb;
      a_nxt.mn   = (fr < fgn) ? fr : fgn;
      a_nxt.diff = $signed({1'b0, fr}) - $signed({1'b0, fgn});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      a_r <= a_nxt;
    end
  end

  // Stage B: hue numerator over sixty, M = sector offset * d + difference.
  logic [7:0]         d_b;
  logic [10:0]        off_b;
  logic signed [11:0] m_b;

  always_comb begin
    d_b = a_r.mx - a_r.mn;
    unique case (a_r.sec)
      hckr_pkg::SEC_RED:   off_b = a_r.diff[8] ? ({1'b0, d_b, 2'b0} + {2'b0, d_b, 1'b0})
                                              : 11'd0;
      hckr_pkg::SEC_GREEN: off_b = {2'b0, d_b, 1'b0};
      hckr_pkg::SEC_BLUE:  off_b = {1'b0, d_b, 2'b0};
      default:             off_b = 11'd0;
    endcase
    m_b = $signed({1'b0, off_b}) + {{3{a_r.diff[8]}}, a_r.diff};
    b_nxt.fg   = a_r.fg;
    b_nxt.bg   = a_r.bg;
    b_nxt.mx   = a_r.mx;
    b_nxt.d    = d_b;
    b_nxt.grey = (a_r.sec == hckr_pkg::SEC_GREY);
    b_nxt.m    = m_b[10:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      b_r <= b_nxt;
    end
  end

  // Stage C: numerator N = 60*M, key-range products and the saturation dividend.
  always_comb begin
    c_nxt.fg   = b_r.fg;
    c_nxt.bg   = b_r.bg;
    c_nxt.mx   = b_r.mx;
    c_nxt.d    = b_r.d;
    c_nxt.grey = b_r.grey;
    c_nxt.n    = {b_r.m, 6'b0} - {4'b0, b_r.m, 2'b0};
    c_nxt.lo_p = {8'b0, hue_low_r} * {9'b0, b_r.d};
    c_nxt.hi_p = {8'b0, hue_high_r} * {9'b0, b_r.d};
    c_nxt.sd   = {b_r.d, 8'b0} - {8'b0, b_r.d};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      c_r <= c_nxt;
    end
  end

  // Division stages. The dividend 16*N is below d * 2^13 and d*255 is below
  // mx * 2^8, so the top bits already form a remainder below the divisor.
  for (genvar j = 0; j < HB; j++) begin : g_div
    hckr_pkg::st_div_t src;
    hckr_pkg::st_div_t nxt;
    logic [8:0]        hs;
    logic [8:0]        ss;

    if (j == 0) begin : g_first
      always_comb begin
        src.fg   = c_r.fg;
        src.bg   = c_r.bg;
        src.mx   = c_r.mx;
        src.d    = c_r.d;
        src.grey = c_r.grey;
        src.key  = !c_r.grey && (c_r.n > c_r.lo_p) && (c_r.n < c_r.hi_p) &&
                   (c_r.mx > value_min_r);
        src.hrem = c_r.n[16:9];
        src.hq   = {c_r.n[8:0], 4'b0};
        src.srem = c_r.sd[15:8];
        src.sq   = c_r.sd[7:0];
      end
    end else begin : g_next
      assign src = dv_r[j-1];
    end

    always_comb begin
      nxt = src;
      hs  = hckr_pkg::div_step(src.hrem, src.hq[HB-1], src.d);
      ss  = hckr_pkg::div_step(src.srem, src.sq[hckr_pkg::SAT_BITS-1], src.mx);
      nxt.hrem = hs[7:0];
      nxt.hq   = {src.hq[HB-2:0], hs[8]};
      if (j < hckr_pkg::SAT_BITS) begin
        nxt.srem = ss[7:0];
        nxt.sq   = {src.sq[hckr_pkg::SAT_BITS-2:0], ss[8]};
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en[FS+j]) begin
        dv_r[j] <= nxt;
      end
    end
  end

  // Output word, taken straight from the last stage.
  hckr_pkg::st_div_t last;
  logic [23:0]       pix;
  logic [12:0]       hue;
  logic [7:0]        sat;

  assign last = dv_r[HB-1];
  assign pix  = last.key ? last.bg : last.fg;
  assign hue  = last.grey ? 13'd0 : last.hq;
  assign sat  = last.grey ? 8'd0 : last.sq;

  assign out_tvalid = ctl.vld[hckr_pkg::NSTG-1];
  assign out_tdata  = {3'b0, last.mx, sat, hue, pix};
  assign out_tuser  = last.key;

endmodule

>>> src/hckr_pipe_ctl.sv
module hckr_pipe_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_ready,
  output logic               in_ready,
  output hckr_pkg::pipe_ctl_t ctl
);

  logic [hckr_pkg::NSTG-1:0] vld_r;
  logic [hckr_pkg::NSTG-1:0] vld_nxt;
  logic [hckr_pkg::NSTG-1:0] en;

  // A stage may load when it is empty or when the stage after it moves on,
  // so bubbles close up while the receiver stalls.
  always_comb begin
    en[hckr_pkg::NSTG-1] = !vld_r[hckr_pkg::NSTG-1] || out_ready;
    for (int k = hckr_pkg::NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < hckr_pkg::NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready = en[0];
  assign ctl.en   = en;
  assign ctl.vld  = vld_r;

endmodule

>>> bench/tb_hsv_chroma_key_replace.sv
`timescale 1ns / 1ps

module tb_hsv_chroma_key_replace;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          NUM_PHASES  = 9;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        keyed;
    logic [12:0] hue;
    logic [7:0]  sat;
    logic [7:0]  bright;
  } pixel_result_t;

  typedef struct {
    logic [23:0]   fg;
    logic [23:0]   bg;
    bit            typed;
    pixel_result_t res;
  } pixel_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  // Key range as the block should hold it.
  logic [8:0] hue_low;
  logic [8:0] hue_high;
  logic [7:0] value_min;

  pixel_result_t pending_pixels[$];
  pixel_row_t    pixel_rows[$];
  pixel_result_t got_pixel;
  idle_mode_t    idle_mode;
  int            mismatch_count;
  int            cycle_count;

  int send_idle_pct[4] = '{0, 57, 0, 14};
  int recv_idle_pct[4] = '{0, 0, 57, 14};

  // Phase settings; -1 asks for a random value.
  int         phase_lo[NUM_PHASES]   = '{88, 0, 359, 0, 511, 60, -1, 200, -1};
  int         phase_hi[NUM_PHASES]   = '{175, 360, 0, 511, 511, 180, -1, 300, -1};
  int         phase_vmin[NUM_PHASES] = '{120, 0, 255, 254, 0, 30, -1, 50, -1};
  idle_mode_t phase_idle[NUM_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                         IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                         IDLE_NONE};

  hsv_chroma_key_replace u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [23:0] rgb(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    rgb = {b, g, r};
  endfunction

  // Converts the foreground to HSV, decides the key and picks the output pixel.
  function automatic pixel_result_t key_and_composite(input logic [23:0] fg,
                                                      input logic [23:0] bg);
    int r, g, b, mx, mn, d, num;
    bit hit;
    pixel_result_t res;
    r   = int'(fg[7:0]);
    g   = int'(fg[15:8]);
    b   = int'(fg[23:16]);
    num = 0;
    hit = 1'b0;
    if (r == g && g == b) begin
      mx = r;
      mn = r;
    end else if (r >= g && r >= b) begin
      mx  = r;
      mn  = (g < b) ? g : b;
      num = 60 * (g - b);
      if (num < 0) num += 360 * (mx - mn);
    end else if (g >= b) begin
      mx  = g;
      mn  = (r < b) ? r : b;
      num = 60 * (2 * (mx - mn) + b - r);
    end else begin
      mx  = b;
      mn  = (r < g) ? r : g;
      num = 60 * (4 * (mx - mn) + r - g);
    end
    d          = mx - mn;
    res.hue    = '0;
    res.sat    = '0;
    res.bright = 8'(mx);
    if (d > 0) begin
      res.hue = 13'((16 * num) / d);
      res.sat = 8'((d * 255) / mx);
      // The key test works on the exact rational hue, never the truncated one.
      hit = (num > int'(hue_low) * d) && (num < int'(hue_high) * d) &&
            (mx > int'(value_min));
    end
    res.keyed = hit;
    {res.blue, res.green, res.red} = hit ? bg[23:0] : fg;
    key_and_composite = res;
  endfunction

  function automatic void add_row(input logic [23:0] fg, input logic [23:0] bg,
                                  input bit typed, input pixel_result_t res);
    pixel_row_t row;
    row.fg    = fg;
    row.bg    = bg;
    row.typed = typed;
    row.res   = res;
    pixel_rows.push_back(row);
  endfunction

  function automatic logic [23:0] pick_pixel();
    logic [7:0] r, g, b, v, lo;
    int         spot;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4: begin
        v = 8'($urandom);
        r = v;
        g = v;
        b = v;
      end
      5: begin
        r = $urandom_range(0, 1) ? 8'hFF - 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 1));
        g = $urandom_range(0, 1) ? 8'hFF - 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 1));
        b = $urandom_range(0, 1) ? 8'hFF - 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 1));
      end
      6: begin
        // Two channels share the maximum.
        v    = 8'($urandom_range(1, 255));
        lo   = 8'($urandom_range(0, v));
        spot = int'($urandom_range(0, 2));
        r    = (spot == 0) ? lo : v;
        g    = (spot == 1) ? lo : v;
        b    = (spot == 2) ? lo : v;
      end
      default: begin
        // Greenish pixels land near the default key range.
        g = 8'($urandom_range(64, 255));
        r = 8'($urandom_range(0, g));
        b = 8'($urandom_range(0, g));
      end
    endcase
    pick_pixel = rgb(r, g, b);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pixel(input logic [23:0] fg, input logic [23:0] bg,
                            input bit typed, input pixel_result_t res);
    while ($urandom_range(0, 99) < send_idle_pct[idle_mode]) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bg, fg};
    do @(posedge clk); while (!in_tready);
    pending_pixels.push_back(typed ? res : key_and_composite(fg, bg));
    @(negedge clk);
  endtask

  task automatic apply_key_setting(input logic [8:0] lo, input logic [8:0] hi,
                                   input logic [8:0] vmin, input bit spare_write);
    logic [1:0] idx;
    logic [8:0] val;
    for (int i = 0; i < (spare_write ? 4 : 3); i++) begin
      idx = 2'(i);
      case (idx)
        hckr_pkg::REG_HUE_LOW:   val = lo;
        hckr_pkg::REG_HUE_HIGH:  val = hi;
        hckr_pkg::REG_VALUE_MIN: val = vmin;
        default:                 val = 9'($urandom);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        hckr_pkg::REG_HUE_LOW:   hue_low = val;
        hckr_pkg::REG_HUE_HIGH:  hue_high = val;
        hckr_pkg::REG_VALUE_MIN: value_min = val[7:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_pipeline();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (hckr_pkg::NSTG + 4) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct[idle_mode]);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("output word with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        got_pixel = pending_pixels.pop_front();
        check_field("out_red", int'(got_pixel.red), int'(out_tdata[7:0]));
        check_field("out_green", int'(got_pixel.green), int'(out_tdata[15:8]));
        check_field("out_blue", int'(got_pixel.blue), int'(out_tdata[23:16]));
        check_field("keyed", int'(got_pixel.keyed), int'(out_tuser));
        check_field("hue_sixteenths", int'(got_pixel.hue), int'(out_tdata[36:24]));
        check_field("saturation", int'(got_pixel.sat), int'(out_tdata[44:37]));
        check_field("brightness", int'(got_pixel.bright), int'(out_tdata[52:45]));
      end
    end
  end

  initial begin
    logic [23:0] white_bg;
    logic [23:0] dark_bg;
    logic [8:0]  lo, hi, vmin;
    white_bg       = rgb(8'hFF, 8'hFF, 8'hFF);
    dark_bg        = rgb(8'h00, 8'h00, 8'h00);
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    idle_mode      = IDLE_NONE;
    mismatch_count = 0;
    cycle_count    = 0;
    hue_low        = hckr_pkg::HUE_LOW_RST;
    hue_high       = hckr_pkg::HUE_HIGH_RST;
    value_min      = hckr_pkg::VALUE_MIN_RST;

    // Directed pixels under the reset key range (88 to 175 degrees, value above 120).
    add_row(rgb(0, 0, 0), white_bg, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 13'd0, 8'd0, 8'd0});
    add_row(rgb(255, 255, 255), dark_bg, 1'b1,
            '{8'd255, 8'd255, 8'd255, 1'b0, 13'd0, 8'd0, 8'd255});
    add_row(rgb(128, 128, 128), white_bg, 1'b1,
            '{8'd128, 8'd128, 8'd128, 1'b0, 13'd0, 8'd0, 8'd128});
    add_row(rgb(255, 0, 0), white_bg, 1'b1,
            '{8'd255, 8'd0, 8'd0, 1'b0, 13'd0, 8'd255, 8'd255});
    add_row(rgb(0, 255, 0), white_bg, 1'b1,
            '{8'd255, 8'd255, 8'd255, 1'b1, 13'd1920, 8'd255, 8'd255});
    add_row(rgb(0, 255, 0), dark_bg, 1'b1,
            '{8'd0, 8'd0, 8'd0, 1'b1, 13'd1920, 8'd255, 8'd255});
    add_row(rgb(0, 0, 255), white_bg, 1'b1,
            '{8'd0, 8'd0, 8'd255, 1'b0, 13'd3840, 8'd255, 8'd255});
    // Ties: red beats green and blue, green beats blue.
    add_row(rgb(255, 255, 0), white_bg, 1'b1,
            '{8'd255, 8'd255, 8'd0, 1'b0, 13'd960, 8'd255, 8'd255});
    add_row(rgb(255, 0, 255), white_bg, 1'b1,
            '{8'd255, 8'd0, 8'd255, 1'b0, 13'd4800, 8'd255, 8'd255});
    add_row(rgb(0, 255, 255), white_bg, 1'b1,
            '{8'd0, 8'd255, 8'd255, 1'b0, 13'd2880, 8'd255, 8'd255});
    // Value exactly on the threshold is not keyed; one above is.
    add_row(rgb(0, 120, 0), white_bg, 1'b1,
            '{8'd0, 8'd120, 8'd0, 1'b0, 13'd1920, 8'd255, 8'd120});
    add_row(rgb(0, 121, 0), white_bg, 1'b1,
            '{8'd255, 8'd255, 8'd255, 1'b1, 13'd1920, 8'd255, 8'd121});
    // Hue exactly on either bound is outside the range.
    add_row(rgb(80, 150, 0), white_bg, 1'b1,
            '{8'd80, 8'd150, 8'd0, 1'b0, 13'd1408, 8'd255, 8'd150});
    add_row(rgb(79, 150, 0), rgb(8'h5A, 8'hA5, 8'h3C), 1'b0, '0);
    add_row(rgb(0, 240, 220), white_bg, 1'b1,
            '{8'd0, 8'd240, 8'd220, 1'b0, 13'd2800, 8'd255, 8'd240});
    add_row(rgb(0, 240, 219), rgb(8'hA5, 8'h5A, 8'hC3), 1'b0, '0);
    add_row(rgb(1, 0, 0), white_bg, 1'b0, '0);
    add_row(rgb(255, 0, 1), white_bg, 1'b0, '0);
    add_row(rgb(254, 255, 253), white_bg, 1'b0, '0);
    add_row(rgb(100, 200, 150), rgb(8'h01, 8'h80, 8'hFE), 1'b0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (pixel_rows[i]) begin
      send_pixel(pixel_rows[i].fg, pixel_rows[i].bg, pixel_rows[i].typed, pixel_rows[i].res);
    end
    in_tvalid <= 1'b0;
    drain_pipeline();

    for (int p = 0; p < NUM_PHASES; p++) begin
      lo        = (phase_lo[p] < 0) ? 9'($urandom) : 9'(phase_lo[p]);
      hi        = (phase_hi[p] < 0) ? 9'($urandom) : 9'(phase_hi[p]);
      vmin      = (phase_vmin[p] < 0) ? 9'($urandom_range(0, 255)) : 9'(phase_vmin[p]);
      // A write to the spare index must leave the key range alone.
      apply_key_setting(lo, hi, vmin, p == 5);
      idle_mode = phase_idle[p];
      repeat (54) send_pixel(pick_pixel(), 24'($urandom), 1'b0, '0);
      in_tvalid <= 1'b0;
      drain_pipeline();
      idle_mode = IDLE_NONE;
    end

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
src/hckr_pkg.sv
src/hckr_pipe_ctl.sv
src/hsv_chroma_key_replace.sv
bench/tb_hsv_chroma_key_replace.sv
